FILE: rtl/swsfr_pkg.sv
// Shared types and constants for the single-wire sensor frame reader.
package swsfr_pkg;

    // Number of sensor lines served by the reader.
    localparam int NUM_CHANNELS = 7;
    localparam logic [3:0] CHAN_LIMIT = 4'(NUM_CHANNELS);

    // Bits in one sensor frame: four data bytes and a checksum byte.
    localparam logic [5:0] TOTAL_BITS = 6'd40;

    // Configuration register indexes.
    localparam logic [2:0] CFG_START_LOW     = 3'd0;
    localparam logic [2:0] CFG_RELEASE_WAIT  = 3'd1;
    localparam logic [2:0] CFG_SAMPLE_DELAY  = 3'd2;
    localparam logic [2:0] CFG_RESP_TIMEOUT  = 3'd3;
    localparam logic [2:0] CFG_BIT_TIMEOUT   = 3'd4;

    // Reset values of the configuration registers.
    localparam logic [15:0] RST_START_LOW    = 16'd5000;
    localparam logic [15:0] RST_RELEASE_WAIT = 16'd40;
    localparam logic [15:0] RST_SAMPLE_DELAY = 16'd27;
    localparam logic [15:0] RST_RESP_TIMEOUT = 16'd128;
    localparam logic [15:0] RST_BIT_TIMEOUT  = 16'd256;

    // Completion status of a reading.
    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_NO_RESPONSE  = 3'd1,
        ST_RESP_LOW_TO  = 3'd2,
        ST_RESP_HIGH_TO = 3'd3,
        ST_BIT_TO       = 3'd4,
        ST_CHECKSUM     = 3'd5
    } t_status;

    // Input item: a tick carrying the line level, or a start request.
    typedef struct packed {
        logic       kind;
        logic [2:0] channel;
        logic       line_level;
    } t_in_item;

    // Result item: state of the reader after one input item.
    typedef struct packed {
        logic        drive_low;
        logic        busy_res;
        logic        done_res;
        t_status     status;
        logic [2:0]  failed_byte;
        logic [2:0]  reading_channel;
        logic [15:0] humidity_raw;
        logic [15:0] temperature_raw;
    } t_out_item;

    // Timing configuration seen by the sequencer.
    typedef struct packed {
        logic [15:0] start_low;
        logic [15:0] release_wait;
        logic [15:0] sample_delay;
        logic [15:0] resp_timeout;
        logic [15:0] bit_timeout;
    } t_cfg;

endpackage

FILE: rtl/swsfr_if.sv
// Handshake channel interfaces for input items, result items and configuration writes.
interface swsfr_in_if import swsfr_pkg::*;;
    logic     valid;
    logic     ready;
    t_in_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface swsfr_out_if import swsfr_pkg::*;;
    logic      valid;
    logic      ready;
    t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface swsfr_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [15:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/swsfr_engine.sv
// Reading sequencer: phase control, tick counting, bit capture and per-channel word stores.
module swsfr_engine import swsfr_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    input  t_cfg      i_cfg,
    output t_out_item o_res
);

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_START_LOW = 3'd1,
        PH_RELEASE   = 3'd2,
        PH_RESP_LOW  = 3'd3,
        PH_RESP_HIGH = 3'd4,
        PH_BIT_RISE  = 3'd5,
        PH_BIT_DELAY = 3'd6,
        PH_BIT_FALL  = 3'd7
    } t_phase;

    t_phase      r_phase, n_phase;
    logic [15:0] r_cnt, n_cnt;
    logic [5:0]  r_bit, n_bit;
    logic [2:0]  r_chan, n_chan;
    logic [39:0] r_frame, n_frame;
    logic [15:0] r_hum  [NUM_CHANNELS];
    logic [15:0] r_temp [NUM_CHANNELS];

    logic        done;
    t_status     status;
    logic [2:0]  fin_byte;
    logic        store_wr;
    logic [15:0] cnt_inc;
    logic [5:0]  bit_inc;
    logic        resp_exp;
    logic        bit_exp;
    logic [7:0]  sum;

    assign cnt_inc  = r_cnt + 16'd1;
    assign bit_inc  = r_bit + 6'd1;
    assign resp_exp = (r_cnt >= i_cfg.resp_timeout);
    assign bit_exp  = (r_cnt >= i_cfg.bit_timeout);
    assign sum      = r_frame[39:32] + r_frame[31:24] + r_frame[23:16] + r_frame[15:8];

    // Next state of the sequencer for one item.
    always_comb begin
        n_phase  = r_phase;
        n_cnt    = r_cnt;
        n_bit    = r_bit;
        n_chan   = r_chan;
        n_frame  = r_frame;
        done     = 1'b0;
        status   = ST_OK;
        fin_byte = 3'd0;
        store_wr = 1'b0;
        if (i_item.kind) begin
            // A start is taken only when idle and on an existing channel.
            if (r_phase == PH_IDLE && {1'b0, i_item.channel} < CHAN_LIMIT) begin
                n_chan  = i_item.channel;
                n_phase = PH_START_LOW;
                n_cnt   = 16'd0;
                n_bit   = 6'd0;
            end
        end else begin
            unique case (r_phase)
                PH_IDLE: begin
                end
                PH_START_LOW: begin
                    n_cnt = cnt_inc;
                    if (cnt_inc >= i_cfg.start_low) begin
                        n_phase = PH_RELEASE;
                        n_cnt   = 16'd0;
                    end
                end
                PH_RELEASE: begin
                    n_cnt = cnt_inc;
                    if (cnt_inc >= i_cfg.release_wait) begin
                        n_cnt = 16'd0;
                        if (i_item.line_level) begin
                            n_phase = PH_IDLE;
                            done    = 1'b1;
                            status  = ST_NO_RESPONSE;
                        end else begin
                            n_phase = PH_RESP_LOW;
                        end
                    end
                end
                PH_RESP_LOW: begin
                    if (i_item.line_level) begin
                        n_phase = PH_RESP_HIGH;
                        n_cnt   = 16'd0;
                    end else if (resp_exp) begin
                        n_phase = PH_IDLE;
                        n_cnt   = 16'd0;
                        done    = 1'b1;
                        status  = ST_RESP_LOW_TO;
                    end else begin
                        n_cnt = cnt_inc;
                    end
                end
                PH_RESP_HIGH: begin
                    if (!i_item.line_level) begin
                        n_phase = PH_BIT_RISE;
                        n_cnt   = 16'd0;
                    end else if (resp_exp) begin
                        n_phase = PH_IDLE;
                        n_cnt   = 16'd0;
                        done    = 1'b1;
                        status  = ST_RESP_HIGH_TO;
                    end else begin
                        n_cnt = cnt_inc;
                    end
                end
                PH_BIT_RISE: begin
                    if (i_item.line_level) begin
                        n_phase = PH_BIT_DELAY;
                        n_cnt   = 16'd0;
                    end else if (bit_exp) begin
                        n_phase  = PH_IDLE;
                        n_cnt    = 16'd0;
                        done     = 1'b1;
                        status   = ST_BIT_TO;
                        fin_byte = r_bit[5:3];
                    end else begin
                        n_cnt = cnt_inc;
                    end
                end
                PH_BIT_DELAY: begin
                    n_cnt = cnt_inc;
                    if (cnt_inc >= i_cfg.sample_delay) begin
                        // Bits arrive MSB first, so the frame is a plain shift line.
                        n_frame = {r_frame[38:0], i_item.line_level};
                        n_phase = PH_BIT_FALL;
                        n_cnt   = 16'd0;
                    end
                end
                PH_BIT_FALL: begin
                    if (!i_item.line_level) begin
                        n_bit = bit_inc;
                        n_cnt = 16'd0;
                        if (bit_inc >= TOTAL_BITS) begin
                            n_phase = PH_IDLE;
                            done    = 1'b1;
                            if (sum != r_frame[7:0]) begin
                                status = ST_CHECKSUM;
                            end else begin
                                status   = ST_OK;
                                store_wr = 1'b1;
                            end
                        end else begin
                            n_phase = PH_BIT_RISE;
                        end
                    end else if (bit_exp) begin
                        n_phase  = PH_IDLE;
                        n_cnt    = 16'd0;
                        done     = 1'b1;
                        status   = ST_BIT_TO;
                        fin_byte = r_bit[5:3];
                    end else begin
                        n_cnt = cnt_inc;
                    end
                end
                default: begin
                    n_phase = PH_IDLE;
                end
            endcase
        end
    end

    // Result of the item, showing the state after it.
    always_comb begin
        o_res.drive_low       = (n_phase == PH_START_LOW);
        o_res.busy_res        = (n_phase != PH_IDLE);
        o_res.done_res        = done;
        o_res.status          = status;
        o_res.failed_byte     = fin_byte;
        o_res.reading_channel = n_chan;
        o_res.humidity_raw    = store_wr ? r_frame[39:24] : r_hum[n_chan];
        o_res.temperature_raw = store_wr ? r_frame[23:8]  : r_temp[n_chan];
    end

    // Control state and channel word stores.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_cnt   <= 16'd0;
            r_bit   <= 6'd0;
            r_chan  <= 3'd0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_hum[i]  <= 16'd0;
                r_temp[i] <= 16'd0;
            end
        end else if (i_step) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_bit   <= n_bit;
            r_chan  <= n_chan;
            if (store_wr) begin
                r_hum[r_chan]  <= r_frame[39:24];
                r_temp[r_chan] <= r_frame[23:8];
            end
        end
    end

    // Received frame bits; every bit is written before the frame is checked.
    always_ff @(posedge i_clk) begin
        if (i_step) begin
            r_frame <= n_frame;
        end
    end

    // A finished reading always leaves the sequencer idle.
    a_done_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_step && o_res.done_res |=> r_phase == PH_IDLE)
        else $error("reading finished but sequencer not idle");

    // The bit index never runs past the end of the frame.
    a_bit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_bit <= TOTAL_BITS)
        else $error("bit index beyond frame length");

    // A nonzero status is only reported with a finished reading.
    a_status_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.status != ST_OK |-> o_res.done_res)
        else $error("status reported without completion");

    // Words are stored only on a good frame, which also ends the reading.
    a_store_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        store_wr |-> done && status == ST_OK && r_phase == PH_BIT_FALL)
        else $error("store update outside a good frame");

endmodule

FILE: rtl/single_wire_sensor_frame_reader.sv
// Top level of the single-wire sensor frame reader: channels, configuration and item registers.
//
//   Channel  Modport        Payload
//   i_in     swsfr sink     kind, channel, line_level
//   o_out    swsfr source   drive_low, busy_res, done_res, status, failed_byte,
//                           reading_channel, humidity_raw, temperature_raw
//   i_cfg    swsfr sink     index (3 bits), data (16 bits)
//
// An item is captured in the input register and then passes through the combinational
// sequencer into the result register, from which its result leaves. One item is accepted
// every cycle while the result side takes results; the sequencer updates its whole state
// once per item. A stalled result holds the result register, and the input register then
// fills before the input side stalls. Reset is synchronous and clears the phase, counters,
// channel word stores and configuration registers at once; no clearing pass is needed.
module single_wire_sensor_frame_reader import swsfr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    swsfr_in_if.sink   i_in,
    swsfr_out_if.source o_out,
    swsfr_cfg_if.sink  i_cfg
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_cfg      r_cfg;
    t_out_item res;
    logic      fire;

    // The sequencer advances when an item waits and the result register can take the result.
    assign fire        = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || fire;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_item;
    assign i_cfg.ready = 1'b1;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_low    <= RST_START_LOW;
            r_cfg.release_wait <= RST_RELEASE_WAIT;
            r_cfg.sample_delay <= RST_SAMPLE_DELAY;
            r_cfg.resp_timeout <= RST_RESP_TIMEOUT;
            r_cfg.bit_timeout  <= RST_BIT_TIMEOUT;
        end else if (i_cfg.valid) begin
            unique case (i_cfg.index)
                CFG_START_LOW:    r_cfg.start_low    <= i_cfg.data;
                CFG_RELEASE_WAIT: r_cfg.release_wait <= i_cfg.data;
                CFG_SAMPLE_DELAY: r_cfg.sample_delay <= i_cfg.data;
                CFG_RESP_TIMEOUT: r_cfg.resp_timeout <= i_cfg.data;
                CFG_BIT_TIMEOUT:  r_cfg.bit_timeout  <= i_cfg.data;
                default: begin
                end
            endcase
        end
    end

    // Input and result register valid flags.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_in.ready) begin
                r_in_valid <= i_in.valid;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Input and result payload registers.
    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_item <= i_in.data;
        end
        if (fire) begin
            r_out_item <= res;
        end
    end

    swsfr_engine u_engine (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (fire),
        .i_item  (r_in_item),
        .i_cfg   (r_cfg),
        .o_res   (res)
    );

    // An item waiting in the input register is neither lost nor altered.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !fire |=> r_in_valid && $stable(r_in_item))
        else $error("input item lost while waiting");

    // A result is never overwritten before it is taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        fire |-> !r_out_valid || o_out.ready)
        else $error("result register overwritten");

    // A write to the sample delay register lands in the next cycle.
    a_cfg_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg.valid && i_cfg.index == CFG_SAMPLE_DELAY
        |=> r_cfg.sample_delay == $past(i_cfg.data))
        else $error("sample delay write not applied");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for the single-wire sensor frame reader.
module tb_top;
    import swsfr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 4;
    localparam int RANDOM_ITEMS   = 240;

    // Highest index the configuration channel can carry; indexes past the list are ignored.
    localparam logic [2:0] CFG_INDEX_LAST = 3'd7;

    // Phases of one reading as the predictor tracks them.
    typedef enum logic [3:0] {
        RD_IDLE,
        RD_HOLD_LOW,
        RD_RELEASE,
        RD_RESP_LOW,
        RD_RESP_HIGH,
        RD_BIT_RISE,
        RD_BIT_DELAY,
        RD_BIT_FALL
    } t_rd_phase;

    // Ways in which the emulated sensor can spoil a reading.
    typedef enum int {
        FAULT_NONE,
        FAULT_NO_RESPONSE,
        FAULT_RESP_LOW,
        FAULT_RESP_HIGH,
        FAULT_BIT_RISE,
        FAULT_BIT_FALL,
        FAULT_CHECKSUM
    } t_fault;

    logic i_clk;
    logic i_rst_n;

    swsfr_in_if  in_ch();
    swsfr_out_if out_ch();
    swsfr_cfg_if cfg_ch();

    single_wire_sensor_frame_reader u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    // Predictor state: timing registers, sequencer and per-channel word stores.
    logic [15:0] cfg_regs [5];
    t_rd_phase   rd_phase;
    logic [15:0] rd_ticks;
    logic [5:0]  rd_bit;
    logic [2:0]  rd_channel;
    logic [7:0]  rd_bytes [5];
    logic [15:0] humidity_words [NUM_CHANNELS];
    logic [15:0] temperature_words [NUM_CHANNELS];
    logic        rd_done;
    t_status     rd_status;
    logic [2:0]  rd_fail_byte;

    t_out_item expected_readings [$];
    t_out_item next_reading;

    int src_idle_pct;
    int sink_stall_pct;
    int stray_start_pct;
    int stim_items;
    int error_count;
    int idle_cycles;

    // Clock.
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Return the predictor to its state after reset.
    function automatic void reader_reset();
        cfg_regs[CFG_START_LOW]    = RST_START_LOW;
        cfg_regs[CFG_RELEASE_WAIT] = RST_RELEASE_WAIT;
        cfg_regs[CFG_SAMPLE_DELAY] = RST_SAMPLE_DELAY;
        cfg_regs[CFG_RESP_TIMEOUT] = RST_RESP_TIMEOUT;
        cfg_regs[CFG_BIT_TIMEOUT]  = RST_BIT_TIMEOUT;
        rd_phase   = RD_IDLE;
        rd_ticks   = '0;
        rd_bit     = '0;
        rd_channel = '0;
        for (int i = 0; i < 5; i++) rd_bytes[i] = '0;
        for (int i = 0; i < NUM_CHANNELS; i++) begin
            humidity_words[i]    = '0;
            temperature_words[i] = '0;
        end
    endfunction

    // Close the current reading with the given status.
    function automatic void end_reading(input t_status st);
        rd_done      = 1'b1;
        rd_status    = st;
        rd_fail_byte = (st == ST_BIT_TO) ? rd_bit[5:3] : 3'd0;
        rd_phase     = RD_IDLE;
        rd_ticks     = '0;
    endfunction

    // True once an edge wait has run past its limit; otherwise counts one more tick.
    function automatic bit wait_over(input logic [15:0] limit);
        if (rd_ticks >= limit) return 1'b1;
        rd_ticks = rd_ticks + 16'd1;
        return 1'b0;
    endfunction

    // Advance the sequencer by one tick with the sampled line level.
    function automatic void reader_tick(input logic level);
        logic [2:0] byte_sel;
        logic [7:0] old_bits;
        logic [7:0] sum;
        case (rd_phase)
            RD_HOLD_LOW: begin
                rd_ticks = rd_ticks + 16'd1;
                if (rd_ticks >= cfg_regs[CFG_START_LOW]) begin
                    rd_phase = RD_RELEASE;
                    rd_ticks = '0;
                end
            end
            RD_RELEASE: begin
                rd_ticks = rd_ticks + 16'd1;
                if (rd_ticks >= cfg_regs[CFG_RELEASE_WAIT]) begin
                    if (level) begin
                        end_reading(ST_NO_RESPONSE);
                    end else begin
                        rd_phase = RD_RESP_LOW;
                        rd_ticks = '0;
                    end
                end
            end
            RD_RESP_LOW: begin
                if (level) begin
                    rd_phase = RD_RESP_HIGH;
                    rd_ticks = '0;
                end else if (wait_over(cfg_regs[CFG_RESP_TIMEOUT])) begin
                    end_reading(ST_RESP_LOW_TO);
                end
            end
            RD_RESP_HIGH: begin
                if (!level) begin
                    rd_phase = RD_BIT_RISE;
                    rd_ticks = '0;
                end else if (wait_over(cfg_regs[CFG_RESP_TIMEOUT])) begin
                    end_reading(ST_RESP_HIGH_TO);
                end
            end
            RD_BIT_RISE: begin
                if (level) begin
                    rd_phase = RD_BIT_DELAY;
                    rd_ticks = '0;
                end else if (wait_over(cfg_regs[CFG_BIT_TIMEOUT])) begin
                    end_reading(ST_BIT_TO);
                end
            end
            RD_BIT_DELAY: begin
                rd_ticks = rd_ticks + 16'd1;
                if (rd_ticks >= cfg_regs[CFG_SAMPLE_DELAY]) begin
                    // The first bit of a byte replaces whatever the byte held.
                    byte_sel = rd_bit[5:3];
                    old_bits = (rd_bit[2:0] == 3'd0) ? 8'h00 : rd_bytes[byte_sel];
                    rd_bytes[byte_sel] = {old_bits[6:0], level};
                    rd_phase = RD_BIT_FALL;
                    rd_ticks = '0;
                end
            end
            RD_BIT_FALL: begin
                if (!level) begin
                    rd_bit = rd_bit + 6'd1;
                    if (rd_bit >= TOTAL_BITS) begin
                        // Words are stored only when the checksum byte matches.
                        sum = rd_bytes[0] + rd_bytes[1] + rd_bytes[2] + rd_bytes[3];
                        if (sum != rd_bytes[4]) begin
                            end_reading(ST_CHECKSUM);
                        end else begin
                            humidity_words[rd_channel]    = {rd_bytes[0], rd_bytes[1]};
                            temperature_words[rd_channel] = {rd_bytes[2], rd_bytes[3]};
                            end_reading(ST_OK);
                        end
                    end else begin
                        rd_phase = RD_BIT_RISE;
                        rd_ticks = '0;
                    end
                end else if (wait_over(cfg_regs[CFG_BIT_TIMEOUT])) begin
                    end_reading(ST_BIT_TO);
                end
            end
            default: begin
                rd_phase = RD_IDLE;
            end
        endcase
    endfunction

    // Expected result item for one accepted input item.
    function automatic t_out_item predict_reading(input t_in_item item);
        t_out_item res;
        rd_done      = 1'b0;
        rd_status    = ST_OK;
        rd_fail_byte = 3'd0;
        if (item.kind) begin
            if (rd_phase == RD_IDLE && item.channel < NUM_CHANNELS) begin
                rd_channel = item.channel;
                rd_phase   = RD_HOLD_LOW;
                rd_ticks   = '0;
                rd_bit     = '0;
            end
        end else if (rd_phase != RD_IDLE) begin
            reader_tick(item.line_level);
        end
        res.drive_low       = (rd_phase == RD_HOLD_LOW);
        res.busy_res        = (rd_phase != RD_IDLE);
        res.done_res        = rd_done;
        res.status          = rd_status;
        res.failed_byte     = rd_fail_byte;
        res.reading_channel = rd_channel;
        res.humidity_raw    = humidity_words[rd_channel];
        res.temperature_raw = temperature_words[rd_channel];
        return res;
    endfunction

    // Send one input item, with random idle cycles first, and predict its result.
    task automatic send_item(input t_in_item item);
        @(negedge i_clk);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= item;
        do @(posedge i_clk); while (!in_ch.ready);
        expected_readings.push_back(predict_reading(item));
        stim_items++;
    endtask

    // One tick with the given line level, now and then preceded by a stray start.
    task automatic send_tick(input logic level);
        t_in_item item;
        if ($urandom_range(99) < stray_start_pct) begin
            item.kind       = 1'b1;
            item.channel    = 3'($urandom_range(7));
            item.line_level = 1'($urandom_range(1));
            send_item(item);
        end
        item.kind       = 1'b0;
        item.channel    = 3'($urandom_range(7));
        item.line_level = level;
        send_item(item);
    endtask

    task automatic send_level_run(input logic level, input int count);
        repeat (count) send_tick(level);
    endtask

    // Write one configuration register.
    task automatic write_cfg(input logic [2:0] index, input logic [15:0] value);
        @(negedge i_clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= value;
        do @(posedge i_clk); while (!cfg_ch.ready);
        if (index <= CFG_BIT_TIMEOUT) cfg_regs[index] = value;
        @(negedge i_clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic write_all_cfg(input logic [15:0] start_low, input logic [15:0] release_wait,
                                 input logic [15:0] sample_delay, input logic [15:0] resp_to,
                                 input logic [15:0] bit_to);
        write_cfg(CFG_START_LOW, start_low);
        write_cfg(CFG_RELEASE_WAIT, release_wait);
        write_cfg(CFG_SAMPLE_DELAY, sample_delay);
        write_cfg(CFG_RESP_TIMEOUT, resp_to);
        write_cfg(CFG_BIT_TIMEOUT, bit_to);
    endtask

    // Stop sending and let every expected result arrive, then let the pipeline settle.
    task automatic drain_results();
        @(negedge i_clk);
        in_ch.valid <= 1'b0;
        while (expected_readings.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // A register value of zero behaves as one tick.
    function automatic int eff_ticks(input logic [15:0] value);
        return (value == 16'd0) ? 1 : int'(value);
    endfunction

    // Ticks spent waiting on an edge: mostly short, sometimes exactly at the limit.
    function automatic int pick_wait(input int limit);
        if ($urandom_range(7) == 0 && limit <= 64) return limit;
        return $urandom_range(limit < 3 ? limit : 3);
    endfunction

    // Start a reading and play the sensor's side of the line, optionally with a fault.
    task automatic run_reading(input logic [2:0] chan, input logic [31:0] payload,
                               input t_fault fault, input int fault_bit);
        t_in_item   item;
        logic [7:0] check;
        logic [39:0] frame;
        int resp_lim;
        int bit_lim;
        int delay;
        check = payload[31:24] + payload[23:16] + payload[15:8] + payload[7:0];
        if (fault == FAULT_CHECKSUM) check = check + 8'($urandom_range(255, 1));
        frame    = {payload, check};
        resp_lim = int'(cfg_regs[CFG_RESP_TIMEOUT]);
        bit_lim  = int'(cfg_regs[CFG_BIT_TIMEOUT]);
        delay    = eff_ticks(cfg_regs[CFG_SAMPLE_DELAY]);

        item.kind       = 1'b1;
        item.channel    = chan;
        item.line_level = 1'($urandom_range(1));
        send_item(item);

        // Host holds the line low and the last of these ticks releases it; the level
        // seen is irrelevant.
        repeat (eff_ticks(cfg_regs[CFG_START_LOW])) send_tick(1'($urandom_range(1)));

        // Release, then the sensor must be pulling low at the check.
        send_level_run(1'b1, eff_ticks(cfg_regs[CFG_RELEASE_WAIT]) - 1);
        send_tick(fault == FAULT_NO_RESPONSE);
        if (fault == FAULT_NO_RESPONSE) return;

        // Sensor response: low, then high.
        if (fault == FAULT_RESP_LOW) begin
            send_level_run(1'b0, resp_lim + 1);
            return;
        end
        send_level_run(1'b0, pick_wait(resp_lim));
        send_tick(1'b1);
        if (fault == FAULT_RESP_HIGH) begin
            send_level_run(1'b1, resp_lim + 1);
            return;
        end
        send_level_run(1'b1, pick_wait(resp_lim));
        send_tick(1'b0);

        // Forty bits, most significant first.
        for (int i = 0; i < 40; i++) begin
            if (fault == FAULT_BIT_RISE && i == fault_bit) begin
                send_level_run(1'b0, bit_lim + 1);
                return;
            end
            send_level_run(1'b0, pick_wait(bit_lim));
            send_tick(1'b1);
            repeat (delay - 1) send_tick(1'($urandom_range(1)));
            send_tick(frame[39 - i]);
            if (fault == FAULT_BIT_FALL && i == fault_bit) begin
                send_level_run(1'b1, bit_lim + 1);
                return;
            end
            send_level_run(1'b1, pick_wait(bit_lim));
            send_tick(1'b0);
        end
    endtask

    // Reset values: idle ticks, an out-of-range start, then a reading on the reset
    // lengths whose hold is cut short mid-reading and whose sensor never answers.
    task automatic test_reset_values();
        t_in_item item;
        send_tick(1'b1);
        send_tick(1'b0);
        item.kind       = 1'b1;
        item.channel    = 3'(NUM_CHANNELS);
        item.line_level = 1'b0;
        send_item(item);
        item.channel = 3'd0;
        send_item(item);
        send_level_run(1'b0, 20);
        drain_results();
        // The held count is already past the new length, so the next tick releases.
        write_cfg(CFG_START_LOW, 16'd1);
        send_level_run(1'b1, 1 + int'(RST_RELEASE_WAIT));
        drain_results();
    endtask

    // A good frame, the response failures, and writes to unused indexes.
    task automatic test_status_codes();
        write_all_cfg(16'd3, 16'd2, 16'd2, 16'd4, 16'd5);
        for (logic [2:0] idx = CFG_BIT_TIMEOUT + 3'd1; idx <= CFG_INDEX_LAST; idx++) begin
            write_cfg(idx, 16'($urandom));
            if (idx == CFG_INDEX_LAST) break;
        end
        run_reading(3'($urandom_range(6)), $urandom, FAULT_NONE, 0);
        run_reading(3'($urandom_range(6)), $urandom, FAULT_NO_RESPONSE, 0);
        run_reading(3'($urandom_range(6)), $urandom, FAULT_RESP_LOW, 0);
        run_reading(3'($urandom_range(6)), $urandom, FAULT_RESP_HIGH, 0);
        drain_results();
    endtask

    // All registers at zero: each delay acts as one tick, each wait fails at once.
    // Bit timeouts are placed in every byte of the frame.
    task automatic test_zero_registers();
        write_all_cfg(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        run_reading(3'd5, 32'h8001_7FFE, FAULT_NONE, 0);
        run_reading(3'($urandom_range(6)), $urandom, FAULT_CHECKSUM, 0);
        for (int f = FAULT_NO_RESPONSE; f <= FAULT_RESP_HIGH; f++) begin
            run_reading(3'($urandom_range(6)), $urandom, t_fault'(f), 0);
        end
        for (int b = 0; b < 5; b++) begin
            run_reading(3'($urandom_range(6)), $urandom,
                        (b % 2 == 0) ? FAULT_BIT_RISE : FAULT_BIT_FALL,
                        b * 8 + $urandom_range(7));
        end
        drain_results();
    endtask

    // All registers at their maximum: every phase is entered and waits well inside its limit;
    // a shorter value written mid-reading moves on the timed phases, and line edges the others.
    task automatic test_max_registers();
        t_in_item item;
        write_all_cfg(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        item.kind       = 1'b1;
        item.channel    = 3'd3;
        item.line_level = 1'b0;
        send_item(item);
        send_level_run(1'b0, 16);
        drain_results();
        write_cfg(CFG_START_LOW, 16'd1);
        send_level_run(1'b1, 17);
        drain_results();
        write_cfg(CFG_RELEASE_WAIT, 16'd1);
        send_tick(1'b0);
        send_level_run(1'b0, 16);
        send_tick(1'b1);
        send_level_run(1'b1, 16);
        send_tick(1'b0);
        send_level_run(1'b0, 16);
        send_tick(1'b1);
        send_level_run(1'b1, 16);
        drain_results();
        write_cfg(CFG_SAMPLE_DELAY, 16'd1);
        send_tick(1'b1);
        send_level_run(1'b1, 16);
        drain_results();
        // The falling edge wait has run past a zero limit, so the next tick times out.
        write_cfg(CFG_BIT_TIMEOUT, 16'd0);
        send_tick(1'b1);
        drain_results();
    endtask

    // One reading with random channel, data and outcome.
    task automatic run_random_reading();
        int pick;
        t_fault fault;
        repeat ($urandom_range(3)) send_tick(1'($urandom_range(1)));
        pick  = $urandom_range(11);
        fault = (pick < 6) ? FAULT_NONE : t_fault'(pick - 5);
        run_reading(3'($urandom_range(7)), $urandom, fault, $urandom_range(39));
    endtask

    // Random readings under three idling patterns, each with a fresh short timing setup.
    task automatic test_random_readings();
        int target;
        for (int part = 0; part < 3; part++) begin
            case (part)
                0: begin
                    src_idle_pct   = 8;
                    sink_stall_pct = 45;
                end
                1: begin
                    src_idle_pct   = 45;
                    sink_stall_pct = 8;
                end
                default: begin
                    src_idle_pct   = 0;
                    sink_stall_pct = 0;
                end
            endcase
            write_all_cfg(16'($urandom_range(6, 1)), 16'($urandom_range(6, 1)),
                          16'($urandom_range(4, 1)), 16'($urandom_range(6)),
                          16'($urandom_range(6)));
            stray_start_pct = 2;
            target = stim_items + RANDOM_ITEMS / 3;
            while (stim_items < target) run_random_reading();
            stray_start_pct = 0;
            drain_results();
        end
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endfunction

    // Compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_readings.size() == 0) begin
                $error("result item arrived with no expectation waiting");
                error_count++;
            end else begin
                next_reading = expected_readings.pop_front();
                check_field("drive_low", 16'(next_reading.drive_low), 16'(out_ch.data.drive_low));
                check_field("busy_res", 16'(next_reading.busy_res), 16'(out_ch.data.busy_res));
                check_field("done_res", 16'(next_reading.done_res), 16'(out_ch.data.done_res));
                check_field("status", 16'(next_reading.status), 16'(out_ch.data.status));
                check_field("failed_byte", 16'(next_reading.failed_byte),
                            16'(out_ch.data.failed_byte));
                check_field("reading_channel", 16'(next_reading.reading_channel),
                            16'(out_ch.data.reading_channel));
                check_field("humidity_raw", next_reading.humidity_raw,
                            out_ch.data.humidity_raw);
                check_field("temperature_raw", next_reading.temperature_raw,
                            out_ch.data.temperature_raw);
            end
        end
    end

    // Result side stalls at random.
    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // Watchdog: end the run when no channel has moved an item for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Test sequence.
    initial begin
        in_ch.valid     = 1'b0;
        in_ch.data      = '0;
        cfg_ch.valid    = 1'b0;
        cfg_ch.index    = '0;
        cfg_ch.data     = '0;
        out_ch.ready    = 1'b0;
        i_rst_n         = 1'b0;
        idle_cycles     = 0;
        error_count     = 0;
        stim_items      = 0;
        src_idle_pct    = 8;
        sink_stall_pct  = 45;
        stray_start_pct = 0;
        reader_reset();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_status_codes();
        test_zero_registers();
        test_max_registers();
        test_random_readings();
        drain_results();

        if (error_count == 0 && expected_readings.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
